### sv/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int unsigned MaxHeight = 4096;
	localparam int unsigned SatLimit = 255;
	localparam int unsigned GradW = 11;
	localparam int unsigned SqW = 22;
	localparam int unsigned RootBits = 11;
	localparam int unsigned ChanCount = 3;

	localparam logic [1:0] RegWidth = 2'd0;
	localparam logic [1:0] RegHeight = 2'd1;

	typedef logic [23:0] pix_t;
	typedef logic [7:0] chan_t;

	// one channel's work in flight along the square-root cell chain
	typedef struct packed {
		logic [SqW-1:0]      rem;
		logic [RootBits-1:0] root;
		logic [SqW-1:0]      n;
	} sqrt_lane_t;

	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

	function automatic chan_t chan_of(input pix_t p, input int unsigned k);
		chan_t r;
		r = p[8*(2-k) +: 8];
		return r;
	endfunction

endpackage

### sv/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### sv/sem_cell.sv
// ----------------------------------------------------------------------------
// sem_cell
// One step of the restoring square root: settles one bit of one root.
// ----------------------------------------------------------------------------
module sem_cell
	import sem_pkg::*;
(
	input  logic       clk,
	input  sqrt_lane_t lane_in,
	output sqrt_lane_t lane_out
);

	logic [SqW+1:0] trial;
	logic [SqW+1:0] rem_sh;

	always_comb begin
		rem_sh = {lane_in.rem, lane_in.n[SqW-1 -: 2]};
		trial  = (SqW+2)'({lane_in.root, 2'b01});
	end

	always_ff @(posedge clk) begin
		lane_out.n <= {lane_in.n[SqW-3:0], 2'b00};
		if (rem_sh >= trial) begin
			lane_out.rem  <= SqW'(rem_sh - trial);
			lane_out.root <= {lane_in.root[RootBits-2:0], 1'b1};
		end else begin
			lane_out.rem  <= SqW'(rem_sh);
			lane_out.root <= {lane_in.root[RootBits-2:0], 1'b0};
		end
	end

endmodule

### sv/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel edge magnitude on RGB pixels with two line buffers.
// ----------------------------------------------------------------------------
//  channel | signals                                       | direction
//  input   | valid, ready, cmd, red_in, green_in, blue_in  | in
//  output  | out_valid, out_ready, *_edge, last_of_frame   | out
//  config  | psel, penable, pwrite, paddr, pwdata, prdata  | in/out
//
// A transfer is refused while the line store is busy: it reads the
// column in the cycle of the transfer and writes it back in the next.
// Results pass through the line read, window, kernel, squares, eleven
// root cells and the output queue.
// Hold the input while two results are outstanding, in flight or queued.
// Reset clears counters, window and queue; the line store is not cleared.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb
	import sem_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic        cmd,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red_edge,
	output logic [7:0]  green_edge,
	output logic [7:0]  blue_edge,
	output logic        last_of_frame,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned Depth = RootBits + 3;
	localparam int unsigned FifoDepth = 16;
	localparam int unsigned FW = $clog2(FifoDepth + 1);

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [CW-1:0] eff_w;
	logic [12:0] eff_h;
	logic [CW-1:0] col_q;
	logic [12:0] row_q;
	logic [CW-1:0] c;
	logic acc, live, is_pix, wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_comb begin
		unique case (paddr[2])
			RegWidth[0]: prdata = {21'd0, width_q};
			default:     prdata = {19'd0, height_q};
		endcase
	end

	always_comb begin
		if (width_q == 11'd0) begin
			eff_w = CW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(width_q);
		end
		if (height_q == 13'd0) begin
			eff_h = 13'd1;
		end else if (32'(height_q) > MaxHeight) begin
			eff_h = 13'(MaxHeight);
		end else begin
			eff_h = height_q;
		end
	end

	// fifo room bounds items in flight
	logic [FW-1:0] credit_q;
	logic pop;
	logic busy_q;
	assign ready = ((32'(credit_q) + Depth + 1) <= FifoDepth) & ~busy_q;
	assign acc = valid & ready;
	assign c = (col_q >= eff_w) ? '0 : col_q;
	assign is_pix = ~cmd;
	assign live = acc & (is_pix ? (row_q < eff_h) : (row_q >= eff_h));

	logic [CW-1:0] col_s1;
	logic [12:0] row_s1;
	logic live_s1;
	pix_t pix_s1;
	pix_t up1, up2;
	logic [AW-1:0] line_addr;

	// reads happen in the cycle before writes of the same column: two-step access
	assign line_addr = busy_q ? col_s1[AW-1:0] : c[AW-1:0];

	sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line1 (
		.clk(clk), .we(live_s1), .addr(line_addr), .wdata(pix_s1), .rdata(up1));
	sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line2 (
		.clk(clk), .we(live_s1), .addr(line_addr), .wdata(up1), .rdata(up2));

	logic live_s2;
	logic [CW-1:0] col_s2;
	logic [12:0] row_s2;
	pix_t pix_s2;
	logic [1:0] ph_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 13'd768;
			col_q    <= '0;
			row_q    <= '0;
			live_s1  <= 1'b0;
			busy_q   <= 1'b0;
		end else begin
			live_s1 <= live & ~wr;
			busy_q  <= acc;
			if (wr && paddr[2] == RegWidth[0]) begin
				width_q <= pwdata[10:0];
				col_q <= '0;
				row_q <= '0;
			end else if (wr && paddr[2] == RegHeight[0]) begin
				height_q <= pwdata[12:0];
				col_q <= '0;
				row_q <= '0;
			end else if (live) begin
				if (!is_pix && row_q == eff_h + 13'd1 && c == '0) begin
					col_q <= '0;
					row_q <= '0;
				end else if (32'(c) + 1 >= 32'(eff_w)) begin
					col_q <= '0;
					row_q <= row_q + 13'd1;
				end else begin
					col_q <= c + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= c;
		row_s1 <= row_q;
		pix_s1 <= is_pix ? {red_in, green_in, blue_in} : '0;
	end
	assign ph_q = 2'b00;

	// window and kernel
	pix_t win_q [3][3];
	logic emit_s2, last_s2;
	pix_t w1, w2;

	always_comb begin
		w1 = (row_s1 < 13'd1) ? '0 : up1;
		w2 = (row_s1 < 13'd2) ? '0 : up2;
	end

	logic [CW-1:0] cc;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) win_q[i][j] <= '0;
			live_s2 <= 1'b0;
		end else begin
			live_s2 <= live_s1;
			if (live_s1) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= w2;
				win_q[1][2] <= w1;
				win_q[2][2] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		col_s2 <= col_s1;
		row_s2 <= row_s1;
		emit_s2 <= (row_s1 >= 13'd2) || (row_s1 == 13'd1 && col_s1 >= CW'(1));
		last_s2 <= (row_s1 == eff_h + 13'd1) && (col_s1 == '0);
		pix_s2 <= pix_s1;
	end

	assign cc = (col_s2 == '0) ? eff_w - CW'(1) : col_s2 - CW'(1);

	logic signed [GradW-1:0] gx [ChanCount];
	logic signed [GradW-1:0] gy [ChanCount];
	always_comb begin
		for (int k = 0; k < ChanCount; k++) begin
			logic signed [GradW-1:0] p [3][3];
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p[i][j] = GradW'($signed({1'b0, chan_of(win_q[i][j], k)}));
				end
				if (cc == '0) p[i][0] = '0;
				if (32'(cc) + 1 >= 32'(eff_w)) p[i][2] = '0;
			end
			gx[k] = p[0][2] - p[0][0] + ((p[1][2] - p[1][0]) <<< 1) + p[2][2] - p[2][0];
			gy[k] = p[2][0] - p[0][0] + ((p[2][1] - p[0][1]) <<< 1) + p[2][2] - p[0][2];
		end
	end

	logic signed [GradW-1:0] gx_s3 [ChanCount];
	logic signed [GradW-1:0] gy_s3 [ChanCount];
	tag_t tag_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else begin
			tag_s3.valid <= live_s2 & emit_s2;
			tag_s3.last  <= last_s2;
		end
	end
	always_ff @(posedge clk) begin
		gx_s3 <= gx;
		gy_s3 <= gy;
	end

	sqrt_lane_t sq_s4 [ChanCount];
	sqrt_lane_t lane [ChanCount][RootBits+1];
	tag_t tag_q [RootBits+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= RootBits; s++) tag_q[s] <= '0;
		end else begin
			tag_q[0] <= tag_s3;
			for (int s = 0; s < RootBits; s++) tag_q[s+1] <= tag_q[s];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < ChanCount; k++) begin
			sq_s4[k].n <= SqW'(32'(gx_s3[k] * gx_s3[k]) + 32'(gy_s3[k] * gy_s3[k]));
			sq_s4[k].rem <= '0;
			sq_s4[k].root <= '0;
		end
	end

	for (genvar k = 0; k < ChanCount; k++) begin : g_ch
		assign lane[k][0] = sq_s4[k];
		for (genvar s = 0; s < RootBits; s++) begin : g_cell
			sem_cell u_cell (
				.clk(clk), .lane_in(lane[k][s]), .lane_out(lane[k][s+1]));
		end
	end

	// rounding: n > r*r + r equals remainder > r
	logic [7:0] res [ChanCount];
	always_comb begin
		for (int k = 0; k < ChanCount; k++) begin
			logic [RootBits:0] rr;
			rr = {1'b0, lane[k][RootBits].root} +
				{{RootBits{1'b0}}, (lane[k][RootBits].rem > SqW'(lane[k][RootBits].root))};
			res[k] = (rr > SatLimit) ? 8'(SatLimit) : rr[7:0];
		end
	end

	// result fifo
	logic [24:0] fifo_q [FifoDepth];
	logic [$clog2(FifoDepth)-1:0] wp_q, rp_q;
	logic [FW-1:0] cnt_q;
	logic push;
	logic emit_now;
	assign emit_now = (row_q >= 13'd2) || (row_q == 13'd1 && c >= CW'(1));
	assign push = tag_q[RootBits].valid;
	assign out_valid = credit_q != '0 && cnt_q != '0;
	assign pop = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			credit_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + FW'(push) - FW'(pop);
			credit_q <= credit_q + FW'(acc && live && emit_now) - FW'(pop);
		end
	end
	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= {tag_q[RootBits].last, res[0], res[1], res[2]};
	end

	assign {last_of_frame, red_edge, green_edge, blue_edge} = fifo_q[rp_q];

	logic unused;
	assign unused = ^{pix_s2, ph_q, pwdata[31:13], paddr[1:0], row_s2};

endmodule

### dv/tb_sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_rgb
// Self-checking bench for the RGB Sobel edge magnitude block. Frames of
// random geometry are streamed with drain ticks, stray items and random
// idling on both sides. A predictor with its own line store and window
// computes each expected magnitude, checked in order against the output.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_rgb
	import sem_pkg::*;
;

	localparam int MaxW = 1024;
	localparam int Latency = 15;
	localparam longint CycleLimit = 1200000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} edge_t;

	typedef struct {
		logic       cmd;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       known;
		edge_t      res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        valid = 1'b0;
	logic        ready;
	logic        cmd = 1'b0;
	logic [7:0]  red_in = '0;
	logic [7:0]  green_in = '0;
	logic [7:0]  blue_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  red_edge;
	logic [7:0]  green_edge;
	logic [7:0]  blue_edge;
	logic        last_of_frame;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sobel_edge_magnitude_rgb dut (.*);

	always #1 clk = ~clk;

	// predictor state
	logic [23:0] line_mem [2*MaxW];
	logic [23:0] win [3][3];
	int unsigned col_pos, row_pos;
	logic [10:0] reg_width;
	logic [12:0] reg_height;

	edge_t       expected_edges[$];
	int          typed_check[$];
	edge_t       typed_edges[$];
	int          errors = 0;
	longint      cycles = 0;
	int          hold_cycles = 0;
	int          hold_len = 0;
	bit          hold_tog = 1'b0;
	bit          hold_seen = 1'b0;
	bit          stall_on = 1'b0;

	function automatic logic [7:0] edge_mag(input logic [23:0] w[3][3], input int sh);
		int p[3][3];
		int gx, gy;
		int unsigned n, r;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				p[i][j] = (w[i][j] >> sh) & 8'hff;
		gx = -p[0][0] + p[0][2] - 2*p[1][0] + 2*p[1][2] - p[2][0] + p[2][2];
		gy = -p[0][0] - 2*p[0][1] - p[0][2] + p[2][0] + 2*p[2][1] + p[2][2];
		n = gx*gx + gy*gy;
		r = 0;
		while ((r+1)*(r+1) <= n) r++;
		if (n > r*r + r) r++;
		if (r > 255) r = 255;
		return r[7:0];
	endfunction

	function automatic int unsigned eff_w();
		if (reg_width == 0) return 1;
		if (reg_width > MaxW) return MaxW;
		return reg_width;
	endfunction

	function automatic int unsigned eff_h();
		if (reg_height == 0) return 1;
		if (reg_height > MaxHeight) return MaxHeight;
		return reg_height;
	endfunction

	// returns 1 when the item produces a result
	function automatic bit sobel_predict(input logic c_in, input logic [23:0] px_in,
			output edge_t res);
		int unsigned w, h, c, r, cc;
		logic [23:0] pix, up1, up2;
		logic [23:0] wv [3][3];
		bit last;
		w = eff_w();
		h = eff_h();
		c = col_pos;
		r = row_pos;
		res = '0;
		if (c >= w) c = 0;
		if (!c_in) begin
			if (r >= h) return 0;
			pix = px_in;
		end else begin
			if (r < h) return 0;
			pix = '0;
		end
		up1 = line_mem[c];
		up2 = line_mem[MaxW + c];
		line_mem[MaxW + c] = up1;
		line_mem[c] = pix;
		if (r < 1) up1 = '0;
		if (r < 2) up2 = '0;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = up2;
		win[1][2] = up1;
		win[2][2] = pix;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
		end
		if (!((r >= 2) || (r == 1 && c >= 1))) return 0;
		cc = (c == 0) ? w - 1 : c - 1;
		wv = win;
		if (cc == 0)
			for (int i = 0; i < 3; i++) wv[i][0] = '0;
		if (cc + 1 >= w)
			for (int i = 0; i < 3; i++) wv[i][2] = '0;
		last = (r == h + 1 && c == 0);
		res.red = edge_mag(wv, 16);
		res.green = edge_mag(wv, 8);
		res.blue = edge_mag(wv, 0);
		res.last = last;
		if (last) begin
			col_pos = 0;
			row_pos = 0;
		end
		return 1;
	endfunction

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == RegWidth) reg_width = value[10:0];
		else if (idx == RegHeight) reg_height = value[12:0];
		col_pos = 0;
		row_pos = 0;
	endtask

	task automatic send_item(input logic c_in, input logic [23:0] px, input bit has_typed,
			input edge_t typed);
		edge_t res;
		cmd <= c_in;
		red_in <= px[23:16];
		green_in <= px[15:8];
		blue_in <= px[7:0];
		valid <= 1'b1;
		do @(posedge clk); while (!ready);
		if (sobel_predict(c_in, px, res)) begin
			expected_edges.push_back(res);
			typed_check.push_back(has_typed);
			typed_edges.push_back(typed);
		end
	endtask

	task automatic idle_item();
		valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_edges.size() != 0) @(posedge clk);
		repeat (Latency + 5) @(posedge clk);
	endtask

	// a whole frame with its drain tail, with bursty gaps and stray items
	task automatic run_frame(input int w, input int h, input int noise_pct);
		int gap, burst, total;
		total = w * h;
		burst = $urandom_range(1, 40);
		for (int k = 0; k < total; k++) begin
			if (burst == 0) begin
				gap = $urandom_range(0, 6);
				repeat (gap) idle_item();
				burst = $urandom_range(1, 40);
			end
			burst--;
			if ($urandom_range(0, 99) < noise_pct)
				send_item(1'b1, $urandom, 1'b0, '0);
			send_item(1'b0, $urandom, 1'b0, '0);
		end
		for (int k = 0; k < w + 1; k++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_item(1'b0, $urandom, 1'b0, '0);
			if ($urandom_range(0, 7) == 0) idle_item();
			send_item(1'b1, $urandom, 1'b0, '0);
		end
		valid <= 1'b0;
	endtask

	row_t directed [] = '{
		'{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0},
		'{1'b0, 8'hff, 8'h00, 8'h00, 1'b0, '0},
		'{1'b0, 8'h00, 8'hff, 8'h00, 1'b0, '0},
		'{1'b0, 8'h00, 8'h00, 8'hff, 1'b0, '0},
		'{1'b0, 8'hff, 8'hff, 8'hff, 1'b0, '0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 1'b0, '0},
		'{1'b0, 8'haa, 8'h55, 8'h0f, 1'b0, '0},
		'{1'b0, 8'h55, 8'haa, 8'hf0, 1'b0, '0},
		'{1'b0, 8'hff, 8'hff, 8'hff, 1'b0, '0},
		'{1'b0, 8'h01, 8'h80, 8'h7f, 1'b0, '0},
		'{1'b0, 8'h12, 8'h34, 8'h56, 1'b0, '0},
		'{1'b0, 8'hff, 8'hff, 8'hff, 1'b0, '0},
		'{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0},
		'{1'b0, 8'h99, 8'h99, 8'h99, 1'b0, '0},
		'{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0},
		'{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0},
		'{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0},
		'{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0},
		'{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, '0}
	};

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_cycles <= hold_len;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// receiver: stall pattern plus the long hold-off
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
		end else if (stall_on) begin
			out_ready <= ($urandom_range(0, 3) != 0) && (cycles[5:3] != 3'd5);
		end else begin
			out_ready <= 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			edge_t got, want;
			got = {red_edge, green_edge, blue_edge, last_of_frame};
			if (expected_edges.size() == 0) begin
				errors <= errors + 1;
				if (errors < 10) $display("unexpected result %h", got);
			end else begin
				want = expected_edges.pop_front();
				if (typed_check.pop_front()) want = typed_edges[0];
				void'(typed_edges.pop_front());
				if (got !== want) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("mismatch: expected %h actual %h", want, got);
				end
			end
		end
		if (cycles > CycleLimit) begin
			$display("tb_sobel_edge_magnitude_rgb failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 2*MaxW; i++) line_mem[i] = '0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) win[i][j] = '0;
		col_pos = 0;
		row_pos = 0;
		reg_width = 11'd1024;
		reg_height = 13'd768;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 4x3 frame, then drain
		reg_write(RegWidth, 32'd4);
		reg_write(RegHeight, 32'd3);
		foreach (directed[k])
			send_item(directed[k].cmd, {directed[k].r, directed[k].g, directed[k].b},
				directed[k].known, directed[k].res);
		valid <= 1'b0;
		wait_drained();

		stall_on = 1'b1;
		// extremes of geometry: zero and over-range registers
		reg_write(RegWidth, 32'd0);
		reg_write(RegHeight, 32'd0);
		run_frame(1, 1, 10);
		wait_drained();
		reg_write(RegHeight, 32'h1fff);
		reg_write(RegWidth, 32'h7ff);
		run_frame(100, 1, 0);
		wait_drained();
		reg_write(RegWidth, 32'd1024);
		reg_write(RegHeight, 32'd2);
		hold_len = 400;
		hold_tog = ~hold_tog;
		run_frame(40, 2, 0);
		wait_drained();

		// random frames, mostly small
		for (int f = 0; f < 40; f++) begin
			int w, h;
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 6);
			reg_write(RegWidth, w);
			reg_write(RegHeight, h);
			if (f == 20) begin
				hold_len = 300;
				hold_tog = ~hold_tog;
			end
			stall_on = (f % 5) != 4;
			run_frame(w, h, $urandom_range(0, 15));
			wait_drained();
		end
		reg_write(RegHeight, 32'd4);
		reg_write(RegWidth, 32'd3);
		run_frame(3, 4, 0);
		wait_drained();

		if (errors == 0 && expected_edges.size() == 0)
			$display("tb_sobel_edge_magnitude_rgb passed");
		else
			$display("tb_sobel_edge_magnitude_rgb failed");
		$finish;
	end

endmodule
